>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int FuncW     = 2;
  localparam int DataPortW = 32;
  localparam int StatusW   = 2;

  typedef enum logic [FuncW-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } dq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } dq_state_e;

endpackage

>>> rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface dq_req_if import dq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FuncW-1:0]     func;
  logic [DataPortW-1:0] push_data;

  modport source (output valid, func, push_data, input ready);
  modport sink   (input valid, func, push_data, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; #(parameter int CntW = 5) ();
  logic                 valid;
  logic                 ready;
  logic [DataPortW-1:0] front_value;
  logic [DataPortW-1:0] back_value;
  logic [CntW-1:0]      entries;
  logic                 is_empty;
  logic [StatusW-1:0]   status;

  modport source (output valid, front_value, back_value, entries, is_empty, status,
                  input ready);
  modport sink   (input valid, front_value, back_value, entries, is_empty, status,
                  output ready);
endinterface

>>> rtl/dq_mem.sv
// ----------------------------------------------------------------------------
// dq_mem
// Slot store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module dq_mem #(
  parameter int Depth = 16,
  parameter int DataW = 32,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [DataW-1:0] rdata_a_o,
  output logic [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Head pointer, fill count, operation sequencing and result register.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; #(
  parameter int Depth = 16,
  parameter int DataW = 32,
  parameter int AddrW = 4,
  parameter int CntW  = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dq_req_if.sink           req_i,
  dq_rsp_if.source         rsp_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [DataW-1:0] mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_a_o,
  output logic [AddrW-1:0] mem_raddr_b_o,
  input  logic [DataW-1:0] mem_rdata_a_i,
  input  logic [DataW-1:0] mem_rdata_b_i
);

  localparam int SumW = CntW + 1;

  dq_state_e            state_q, state_d;
  logic [AddrW-1:0]     head_q, head_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  dq_status_e           status_q, status_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [DataPortW-1:0] front_q, back_q;
  logic [CntW-1:0]      out_cnt_q;
  logic                 out_empty_q;
  dq_status_e           out_status_q;

  logic                 full, empty;
  logic [AddrW-1:0]     head_dec, head_inc, tail_addr, back_addr;
  logic [SumW-1:0]      tail_sum, back_sum;
  logic [DataPortW-1:0] front_ext, back_ext;
  dq_op_e               op;

  assign op    = dq_op_e'(req_i.func);
  assign full  = (cnt_q == CntW'(Depth));
  assign empty = (cnt_q == '0);

  assign head_dec = (head_q == '0) ? AddrW'(Depth - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + 1'b1;

  assign tail_sum  = SumW'(head_q) + SumW'(cnt_q);
  assign tail_addr = (tail_sum >= SumW'(Depth)) ? AddrW'(tail_sum - SumW'(Depth))
                                                : AddrW'(tail_sum);
  assign back_sum  = tail_sum - 1'b1;
  assign back_addr = (back_sum >= SumW'(Depth)) ? AddrW'(back_sum - SumW'(Depth))
                                                : AddrW'(back_sum);

  assign mem_raddr_a_o = head_q;
  assign mem_raddr_b_o = back_addr;

  if (DataW >= DataPortW) begin : g_wide
    assign mem_wdata_o = DataW'(req_i.push_data);
    assign front_ext   = mem_rdata_a_i[DataPortW-1:0];
    assign back_ext    = mem_rdata_b_i[DataPortW-1:0];
  end else begin : g_narrow
    assign mem_wdata_o = req_i.push_data[DataW-1:0];
    assign front_ext   = DataPortW'(mem_rdata_a_i);
    assign back_ext    = DataPortW'(mem_rdata_b_i);
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_addr;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          status_d = ST_OK;
          state_d  = S_READ;
          case (op)
            OP_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_OVERFLOW;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = head_dec;
                head_d      = head_dec;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_d = ST_OVERFLOW;
              end else begin
                mem_we_o = 1'b1;
                cnt_d    = cnt_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_d = ST_UNDERFLOW;
              end else begin
                head_d = head_inc;
                cnt_d  = cnt_q - 1'b1;
              end
            end
            default: begin
              if (empty) begin
                status_d = ST_UNDERFLOW;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      front_q      <= empty ? '0 : front_ext;
      back_q       <= empty ? '0 : back_ext;
      out_cnt_q    <= cnt_q;
      out_empty_q  <= empty;
      out_status_q <= status_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.back_value  = back_q;
  assign rsp_o.entries     = out_cnt_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.status      = out_status_q;

endmodule

>>> rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue held in a ring of memory slots.
// ----------------------------------------------------------------------------
// Operations arrive on req_i (func, push_data): push front, push back,
// pop front, pop back. Each transaction on req_i yields exactly one
// transaction on rsp_o carrying the front and back values after the
// operation (zero when empty), the entry count, an empty flag and a status:
// ok, underflow (pop on empty, nothing changes) or overflow (push on full,
// value dropped).
// The write and pointer update happen at the accepting edge, the front and
// back slots are then read through the registered memory ports, and the
// result register loads after that, raising rsp_o.valid; that load waits
// while an earlier result is still stalled in the output register.
// One operation is in flight at a time: req_i.ready is high only while idle,
// so the block takes no new operation until the current one has passed its
// memory read after the write and the load of the result register.
// A stalled result waits in the output register while the next operation
// is accepted and processed; it only advances once the result is taken.
// Reset empties the queue (head and count to zero); slot contents are not
// cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_top import dq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AddrW-1:0]      mem_raddr_a, mem_raddr_b;
  logic [DATA_WIDTH-1:0] mem_rdata_a, mem_rdata_b;

  dq_ctrl #(
    .Depth (DEPTH),
    .DataW (DATA_WIDTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  dq_mem #(
    .Depth (DEPTH),
    .DataW (DATA_WIDTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

>>> rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the queue's result channel.
// ----------------------------------------------------------------------------
module dq_checker import dq_pkg::*; #(
  parameter int Depth = 16,
  parameter int CntW  = 5
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 rsp_valid_i,
  input logic                 rsp_ready_i,
  input logic [DataPortW-1:0] front_i,
  input logic [CntW-1:0]      entries_i,
  input logic                 is_empty_i,
  input logic [StatusW-1:0]   status_i
);

  property p_empty_flag;
    @(posedge clk_i) disable iff (!rst_ni)
      rsp_valid_i |-> (is_empty_i == (entries_i == '0));
  endproperty
  a_empty_flag: assert property (p_empty_flag) else $error("empty flag mismatch");

  property p_underflow_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      (rsp_valid_i && status_i == ST_UNDERFLOW) |-> is_empty_i;
  endproperty
  a_underflow_empty: assert property (p_underflow_empty)
    else $error("underflow on non-empty queue");

  property p_overflow_full;
    @(posedge clk_i) disable iff (!rst_ni)
      (rsp_valid_i && status_i == ST_OVERFLOW) |-> (entries_i == CntW'(Depth));
  endproperty
  a_overflow_full: assert property (p_overflow_full)
    else $error("overflow on non-full queue");

  property p_empty_front_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (rsp_valid_i && is_empty_i) |-> (front_i == '0);
  endproperty
  a_empty_front_zero: assert property (p_empty_front_zero)
    else $error("front value not zero on empty queue");

  property p_rsp_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(front_i)
                                         && $stable(entries_i));
  endproperty
  a_rsp_hold: assert property (p_rsp_hold) else $error("stalled result changed");

endmodule

bind double_ended_queue_top dq_checker #(
  .Depth (DEPTH),
  .CntW  (CntW)
) u_dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .front_i     (rsp_o.front_value),
  .entries_i   (rsp_o.entries),
  .is_empty_i  (rsp_o.is_empty),
  .status_i    (rsp_o.status)
);
